// ===== rtl/owtrs_pkg.sv =====
// ----------------------------------------------------------------------------
// owtrs_pkg
// Types, constants and sequencing functions of the one-wire temperature read
// sequencer.
// ----------------------------------------------------------------------------
package owtrs_pkg;

	localparam int READ_BITS  = 16;
	localparam int WAIT_WIDTH = 20;
	localparam int SHIFT_W    = 16;
	localparam int BIT_W      = $clog2(READ_BITS + 1);
	localparam int LEN_W      = 20;
	localparam int CW         = (WAIT_WIDTH > LEN_W) ? WAIT_WIDTH : LEN_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CW-1:0] WAIT_MAX = CW'({WAIT_WIDTH{1'b1}});

	localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_WAIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_START    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd7;

	localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
	localparam logic [7:0] CMD_CONVERT      = 8'h44;
	localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

	localparam logic [1:0] SLOT_OPEN   = 2'd0;
	localparam logic [1:0] SLOT_HOLD   = 2'd1;
	localparam logic [1:0] SLOT_SAMPLE = 2'd2;
	localparam logic [1:0] SLOT_TAIL   = 2'd3;

	localparam logic [2:0] STEP_SKIP1    = 3'd0;
	localparam logic [2:0] STEP_CONVERT  = 3'd1;
	localparam logic [2:0] STEP_SKIP2    = 3'd2;
	localparam logic [2:0] STEP_READ_CMD = 3'd3;
	localparam logic [2:0] STEP_READING  = 3'd4;

	typedef enum logic [5:0] {
		PH_IDLE     = 6'b000001,
		PH_RESET    = 6'b000010,
		PH_PRESENCE = 6'b000100,
		PH_WRITE    = 6'b001000,
		PH_CONVERT  = 6'b010000,
		PH_READ     = 6'b100000
	} phase_t;

	typedef struct packed {
		logic start_req;
		logic bus_level;
	} tick_t;

	typedef struct packed {
		logic               bus_drive_low;
		logic               busy_res;
		logic               done_res;
		logic signed [15:0] temperature;
	} result_t;

	typedef struct packed {
		logic [15:0] reset_low_us;
		logic [15:0] presence_wait_us;
		logic [19:0] convert_wait_us;
		logic [3:0]  slot_start_us;
		logic [7:0]  write_hold_us;
		logic [7:0]  recovery_us;
		logic [3:0]  read_sample_us;
		logic [7:0]  read_tail_us;
	} cfg_t;

	typedef struct packed {
		phase_t                phase;
		logic [2:0]            step;
		logic [1:0]            slot;
		logic [BIT_W-1:0]      bits;
		logic [7:0]            cmd;
		logic [SHIFT_W-1:0]    shift;
		logic [WAIT_WIDTH-1:0] wc;
		logic [15:0]           reading;
		logic                  done;
	} state_t;

	localparam cfg_t CFG_RESET = '{
		reset_low_us:     16'd1000,
		presence_wait_us: 16'd480,
		convert_wait_us:  20'd750000,
		slot_start_us:    4'd2,
		write_hold_us:    8'd60,
		recovery_us:      8'd2,
		read_sample_us:   4'd5,
		read_tail_us:     8'd50
	};

	localparam state_t ST_RESET = '{
		phase:   PH_IDLE,
		step:    '0,
		slot:    '0,
		bits:    '0,
		cmd:     '0,
		shift:   '0,
		wc:      '0,
		reading: '0,
		done:    1'b0
	};

	function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = CMD_SKIP_ROM;
			2'd1:    b = CMD_CONVERT;
			2'd2:    b = CMD_SKIP_ROM;
			default: b = CMD_READ_SCRATCH;
		endcase
		return b;
	endfunction

	// signed sixteenths of a degree to tenths, truncated toward zero
	function automatic logic [15:0] to_tenths(input logic [SHIFT_W-1:0] raw);
		logic signed [19:0] sx;
		logic signed [19:0] t;
		logic signed [19:0] q;
		sx = 20'(signed'(raw));
		t  = (sx <<< 3) + (sx <<< 1);
		q  = (t + (t[19] ? 20'sd15 : 20'sd0)) >>> 4;
		return q[15:0];
	endfunction

	function automatic logic [CW-1:0] seg_len(input state_t s, input cfg_t c);
		logic [LEN_W-1:0] n;
		case (s.phase)
			PH_RESET:    n = LEN_W'(c.reset_low_us);
			PH_PRESENCE: n = LEN_W'(c.presence_wait_us);
			PH_CONVERT:  n = c.convert_wait_us;
			PH_WRITE: begin
				case (s.slot)
					SLOT_OPEN: n = LEN_W'(c.slot_start_us);
					SLOT_HOLD: n = LEN_W'(c.write_hold_us);
					default:   n = LEN_W'(c.recovery_us);
				endcase
			end
			PH_READ: begin
				case (s.slot)
					SLOT_OPEN:   n = LEN_W'(c.slot_start_us);
					SLOT_HOLD:   n = LEN_W'(c.read_sample_us);
					SLOT_SAMPLE: n = LEN_W'(1);
					default:     n = LEN_W'(c.read_tail_us);
				endcase
			end
			default: n = '0;
		endcase
		return (CW'(n) > WAIT_MAX) ? WAIT_MAX : CW'(n);
	endfunction

	function automatic logic seg_drive(input state_t s);
		logic d;
		case (s.phase)
			PH_RESET: d = 1'b1;
			PH_WRITE: begin
				case (s.slot)
					SLOT_OPEN: d = 1'b1;
					SLOT_HOLD: d = ~s.cmd[s.bits[2:0]];
					default:   d = 1'b0;
				endcase
			end
			PH_READ: d = (s.slot == SLOT_OPEN);
			default: d = 1'b0;
		endcase
		return d;
	endfunction

	function automatic state_t finish(input state_t s);
		state_t r;
		r         = s;
		r.reading = to_tenths(s.shift);
		r.done    = 1'b1;
		r.step    = '0;
		r.slot    = '0;
		r.bits    = '0;
		r.phase   = PH_IDLE;
		return r;
	endfunction

	// end of a write byte: next command byte, conversion wait or read slots
	function automatic state_t byte_end(input state_t s, input logic [1:0] first_slot);
		state_t r;
		r      = s;
		r.bits = '0;
		if (s.step == STEP_SKIP1 || s.step == STEP_SKIP2) begin
			r.step = s.step + 3'd1;
			r.cmd  = cmd_byte(s.step[1:0] + 2'd1);
			r.slot = first_slot;
		end else if (s.step == STEP_CONVERT) begin
			r.step  = STEP_SKIP2;
			r.phase = PH_CONVERT;
			r.slot  = SLOT_OPEN;
		end else begin
			r.step  = STEP_READING;
			r.shift = '0;
			r.phase = PH_READ;
			r.slot  = SLOT_OPEN;
		end
		return r;
	endfunction

	// one segment forward
	function automatic state_t advance(input state_t s);
		state_t           r;
		logic [BIT_W-1:0] nb;
		r  = s;
		nb = s.bits + BIT_W'(1);
		r.wc = '0;
		case (s.phase)
			PH_RESET: r.phase = PH_PRESENCE;
			PH_PRESENCE: begin
				r.phase = PH_WRITE;
				r.cmd   = cmd_byte(s.step[1:0]);
				r.bits  = '0;
				r.slot  = SLOT_OPEN;
			end
			PH_WRITE: begin
				if (s.slot < SLOT_SAMPLE) begin
					r.slot = s.slot + 2'd1;
				end else if (32'(nb) < 8) begin
					r.slot = SLOT_OPEN;
					r.bits = nb;
				end else begin
					r = byte_end(r, SLOT_OPEN);
				end
			end
			PH_CONVERT: r.phase = PH_RESET;
			PH_READ: begin
				if (s.slot < SLOT_TAIL) begin
					r.slot = s.slot + 2'd1;
				end else if (32'(nb) >= READ_BITS) begin
					r = finish(r);
				end else begin
					r.slot = SLOT_OPEN;
					r.bits = nb;
				end
			end
			default: r.phase = PH_IDLE;
		endcase
		return r;
	endfunction

	// reset, presence and conversion: a zero length moves on by one segment
	function automatic state_t skip_plain(input state_t s, input cfg_t c, input phase_t ph);
		state_t r;
		r = s;
		if (s.phase == ph && seg_len(s, c) == '0) begin
			r = advance(s);
		end
		return r;
	endfunction

	// zero-length write segments, collapsed to the first segment with time
	function automatic state_t skip_write(input state_t s, input cfg_t c);
		state_t           r;
		logic             z3;
		logic             z4;
		logic             z5;
		logic [1:0]       first;
		logic [BIT_W-1:0] nb;
		r     = s;
		z3    = (c.slot_start_us == '0);
		z4    = (c.write_hold_us == '0);
		z5    = (c.recovery_us == '0);
		first = !z3 ? SLOT_OPEN : (!z4 ? SLOT_HOLD : SLOT_SAMPLE);
		nb    = s.bits + BIT_W'(1);
		if (s.phase == PH_WRITE && seg_len(s, c) == '0) begin
			r.wc = '0;
			if (z3 && z4 && z5) begin
				r.bits = '0;
				r.slot = SLOT_OPEN;
				if (s.step == STEP_SKIP1 || s.step == STEP_CONVERT) begin
					r.phase = PH_CONVERT;
					r.step  = STEP_SKIP2;
					if (s.step == STEP_SKIP1) begin
						r.cmd = CMD_CONVERT;
					end
				end else begin
					r.phase = PH_READ;
					r.step  = STEP_READING;
					r.shift = '0;
					if (s.step == STEP_SKIP2) begin
						r.cmd = CMD_READ_SCRATCH;
					end
				end
			end else if (s.slot == SLOT_OPEN && !z4) begin
				r.slot = SLOT_HOLD;
			end else if (s.slot <= SLOT_HOLD && !z5) begin
				r.slot = SLOT_SAMPLE;
			end else if (32'(nb) < 8) begin
				r.bits = nb;
				r.slot = first;
			end else begin
				r = byte_end(r, first);
			end
		end
		return r;
	endfunction

	// zero-length read segments; the sample segment always lasts one tick
	function automatic state_t skip_read(input state_t s, input cfg_t c);
		state_t           r;
		logic             z3;
		logic             z6;
		logic [BIT_W-1:0] nb;
		r  = s;
		z3 = (c.slot_start_us == '0);
		z6 = (c.read_sample_us == '0);
		nb = s.bits + BIT_W'(1);
		if (s.phase == PH_READ && seg_len(s, c) == '0) begin
			r.wc = '0;
			case (s.slot)
				SLOT_OPEN: r.slot = !z6 ? SLOT_HOLD : SLOT_SAMPLE;
				SLOT_HOLD: r.slot = SLOT_SAMPLE;
				default: begin
					if (32'(nb) >= READ_BITS) begin
						r = finish(r);
					end else begin
						r.bits = nb;
						r.slot = !z3 ? SLOT_OPEN : (!z6 ? SLOT_HOLD : SLOT_SAMPLE);
					end
				end
			endcase
		end
		return r;
	endfunction

	function automatic state_t normalize(input state_t s, input cfg_t c);
		state_t r;
		r = skip_plain(s, c, PH_RESET);
		r = skip_plain(r, c, PH_PRESENCE);
		r = skip_write(r, c);
		r = skip_plain(r, c, PH_CONVERT);
		r = skip_plain(r, c, PH_RESET);
		r = skip_plain(r, c, PH_PRESENCE);
		r = skip_write(r, c);
		r = skip_read(r, c);
		return r;
	endfunction

endpackage

// ===== rtl/one_wire_temperature_read_sequencer.sv =====
// ----------------------------------------------------------------------------
// one_wire_temperature_read_sequencer
// One-wire master that runs a reset, skip-rom/convert, reset,
// skip-rom/read-scratchpad sequence and returns the temperature in tenths.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   tick     | in        | tick_valid/stall     | start_req, bus_level
//   result   | out       | result_valid/stall   | drive, busy, done, temp
//   cfg      | in        | cfg_write            | cfg_index, cfg_data
//
// one tick transaction per clock unless a stalled result holds the tick register
// the tick register and the result register bound the single sequencing pass
// arst_n resets the sequence state and the config registers and clears both valid bits
// a stalled result holds the tick register, which then stalls the tick channel
// ----------------------------------------------------------------------------
module one_wire_temperature_read_sequencer
	import owtrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  tick_valid,
	output logic                  tick_stall,
	input  tick_t                 tick,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result
);

	cfg_t    cfg_q;
	state_t  st_q;
	state_t  st_start;
	state_t  st_norm;
	state_t  st_next;
	logic    valid_s1;
	tick_t   tick_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result_next;
	logic    move;
	logic    drive;
	logic [WAIT_WIDTH-1:0] wc_inc;

	assign move       = ~valid_s2 | ~result_stall;
	assign tick_stall = valid_s1 & ~move;

	always_comb begin
		st_start = st_q;
		if (st_q.phase == PH_IDLE && tick_s1.start_req) begin
			st_start.done  = 1'b0;
			st_start.step  = '0;
			st_start.slot  = '0;
			st_start.bits  = '0;
			st_start.wc    = '0;
			st_start.phase = PH_RESET;
		end
		st_norm = normalize(st_start, cfg_q);
		st_next = st_norm;
		drive   = 1'b0;
		wc_inc  = st_norm.wc + WAIT_WIDTH'(1);
		if (st_norm.phase != PH_IDLE) begin
			drive = seg_drive(st_norm);
			if (st_norm.phase == PH_READ && st_norm.slot == SLOT_SAMPLE &&
			    32'(st_norm.bits) < SHIFT_W && tick_s1.bus_level) begin
				st_next.shift[st_norm.bits[$clog2(SHIFT_W)-1:0]] = 1'b1;
			end
			if (CW'(wc_inc) >= seg_len(st_norm, cfg_q)) begin
				st_next = advance(st_next);
			end else begin
				st_next.wc = wc_inc;
			end
		end
		result_next.bus_drive_low = drive;
		result_next.busy_res      = (st_next.phase != PH_IDLE);
		result_next.done_res      = st_next.done;
		result_next.temperature   = signed'(st_next.reading);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_RESET_LOW:     cfg_q.reset_low_us     <= cfg_data[15:0];
				CFG_PRESENCE_WAIT: cfg_q.presence_wait_us <= cfg_data[15:0];
				CFG_CONVERT_WAIT:  cfg_q.convert_wait_us  <= cfg_data[19:0];
				CFG_SLOT_START:    cfg_q.slot_start_us    <= cfg_data[3:0];
				CFG_WRITE_HOLD:    cfg_q.write_hold_us    <= cfg_data[7:0];
				CFG_RECOVERY:      cfg_q.recovery_us      <= cfg_data[7:0];
				CFG_READ_SAMPLE:   cfg_q.read_sample_us   <= cfg_data[3:0];
				CFG_READ_TAIL:     cfg_q.read_tail_us     <= cfg_data[7:0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= ST_RESET;
		end else begin
			if (!tick_stall) begin
				valid_s1 <= tick_valid;
			end
			if (move) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					st_q <= st_next;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!tick_stall && tick_valid) begin
			tick_s1 <= tick;
		end
		if (move && valid_s1) begin
			result_s2 <= result_next;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// ===== verif/owtrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owtrs_checker
// Watches the tick, result and register channels of the one-wire temperature
// read sequencer. Each accepted tick transaction is run through a cycle model
// of the bus sequence (reset pulses, command write slots, conversion wait,
// read slots, signed conversion to tenths), and every accepted result is
// compared field by field against the oldest status still due.
// ----------------------------------------------------------------------------
module owtrs_checker
	import owtrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  tick_valid,
	input  logic                  tick_stall,
	input  tick_t                 tick,
	input  logic                  result_valid,
	input  logic                  result_stall,
	input  result_t               result,
	output int                    errors,
	output int                    outstanding
);

	cfg_t                  regs;
	phase_t                ph;
	logic [2:0]            step;
	logic [1:0]            slot;
	logic [4:0]            nbit;
	logic [7:0]            cmd;
	logic [15:0]           raw;
	logic [WAIT_WIDTH-1:0] wc;
	logic [15:0]           reading;
	logic                  done;

	result_t status_due[$];
	result_t forecast;
	result_t want;
	int      results_seen;

	task automatic flag_mismatch(input string what, input int got, input int exp_val);
		$display("result %0d: %s got %0d, expected %0d", results_seen, what, got, exp_val);
		errors++;
	endtask

	function automatic logic [7:0] command_for(input logic [2:0] s);
		logic [7:0] b;
		case (s)
			STEP_SKIP1, STEP_SKIP2: b = CMD_SKIP_ROM;
			STEP_CONVERT:           b = CMD_CONVERT;
			default:                b = CMD_READ_SCRATCH;
		endcase
		return b;
	endfunction

	function automatic logic [31:0] segment_ticks();
		logic [31:0] n;
		case (ph)
			PH_RESET:    n = 32'(regs.reset_low_us);
			PH_PRESENCE: n = 32'(regs.presence_wait_us);
			PH_CONVERT:  n = 32'(regs.convert_wait_us);
			PH_WRITE: begin
				if (slot == SLOT_OPEN) n = 32'(regs.slot_start_us);
				else if (slot == SLOT_HOLD) n = 32'(regs.write_hold_us);
				else n = 32'(regs.recovery_us);
			end
			PH_READ: begin
				case (slot)
					SLOT_OPEN:   n = 32'(regs.slot_start_us);
					SLOT_HOLD:   n = 32'(regs.read_sample_us);
					SLOT_SAMPLE: n = 32'd1;
					default:     n = 32'(regs.read_tail_us);
				endcase
			end
			default: n = 32'd0;
		endcase
		if (n > 32'(WAIT_MAX)) n = 32'(WAIT_MAX);
		return n;
	endfunction

	function automatic logic pulls_low();
		logic d;
		case (ph)
			PH_RESET: d = 1'b1;
			PH_WRITE: begin
				if (slot == SLOT_OPEN) d = 1'b1;
				else if (slot == SLOT_HOLD) d = ~cmd[nbit[2:0]];
				else d = 1'b0;
			end
			PH_READ: d = (slot == SLOT_OPEN);
			default: d = 1'b0;
		endcase
		return d;
	endfunction

	task automatic store_reading();
		int sx;
		int q;
		sx = int'($signed(raw));
		// int division truncates toward zero
		q = (sx * 10) / 16;
		reading = q[15:0];
		done = 1'b1;
		step = STEP_SKIP1;
		slot = SLOT_OPEN;
		nbit = '0;
		ph = PH_IDLE;
	endtask

	task automatic next_segment();
		wc = '0;
		case (ph)
			PH_RESET: ph = PH_PRESENCE;
			PH_PRESENCE: begin
				ph = PH_WRITE;
				cmd = command_for(step);
				nbit = '0;
				slot = SLOT_OPEN;
			end
			PH_WRITE: begin
				if (slot < SLOT_SAMPLE) begin
					slot = slot + 2'd1;
				end else begin
					slot = SLOT_OPEN;
					nbit = nbit + 5'd1;
					if (nbit >= 5'd8) begin
						nbit = '0;
						if (step == STEP_SKIP1 || step == STEP_SKIP2) begin
							step = step + 3'd1;
							cmd = command_for(step);
						end else if (step == STEP_CONVERT) begin
							step = STEP_SKIP2;
							ph = PH_CONVERT;
						end else begin
							step = STEP_READING;
							raw = '0;
							ph = PH_READ;
						end
					end
				end
			end
			PH_CONVERT: ph = PH_RESET;
			PH_READ: begin
				if (slot < SLOT_TAIL) begin
					slot = slot + 2'd1;
				end else begin
					slot = SLOT_OPEN;
					nbit = nbit + 5'd1;
					if (32'(nbit) >= READ_BITS) store_reading();
				end
			end
			default: ph = PH_IDLE;
		endcase
	endtask

	task automatic step_sequencer(input tick_t t, output result_t r);
		logic        drv;
		logic [31:0] len;
		int          guard;
		drv = 1'b0;
		if (ph == PH_IDLE && t.start_req) begin
			done = 1'b0;
			step = STEP_SKIP1;
			slot = SLOT_OPEN;
			nbit = '0;
			wc = '0;
			ph = PH_RESET;
		end
		// zero-length segments are passed in the same tick
		guard = 0;
		while (guard < 4096 && ph != PH_IDLE && segment_ticks() == 0) begin
			next_segment();
			guard++;
		end
		if (ph != PH_IDLE) begin
			len = segment_ticks();
			drv = pulls_low();
			if (ph == PH_READ && slot == SLOT_SAMPLE && nbit < 5'd16 && t.bus_level) begin
				raw[nbit[3:0]] = 1'b1;
			end
			wc = wc + 1'b1;
			if (32'(wc) >= len) next_segment();
		end
		r.bus_drive_low = drv;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = done;
		r.temperature = reading;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.reset_low_us = 16'd1000;
			regs.presence_wait_us = 16'd480;
			regs.convert_wait_us = 20'd750000;
			regs.slot_start_us = 4'd2;
			regs.write_hold_us = 8'd60;
			regs.recovery_us = 8'd2;
			regs.read_sample_us = 4'd5;
			regs.read_tail_us = 8'd50;
			ph = PH_IDLE;
			step = STEP_SKIP1;
			slot = SLOT_OPEN;
			nbit = '0;
			cmd = '0;
			raw = '0;
			wc = '0;
			reading = '0;
			done = 1'b0;
			status_due.delete();
			results_seen = 0;
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_RESET_LOW:     regs.reset_low_us = cfg_data[15:0];
					CFG_PRESENCE_WAIT: regs.presence_wait_us = cfg_data[15:0];
					CFG_CONVERT_WAIT:  regs.convert_wait_us = cfg_data[19:0];
					CFG_SLOT_START:    regs.slot_start_us = cfg_data[3:0];
					CFG_WRITE_HOLD:    regs.write_hold_us = cfg_data[7:0];
					CFG_RECOVERY:      regs.recovery_us = cfg_data[7:0];
					CFG_READ_SAMPLE:   regs.read_sample_us = cfg_data[3:0];
					default:           regs.read_tail_us = cfg_data[7:0];
				endcase
			end
			if (tick_valid && !tick_stall) begin
				step_sequencer(tick, forecast);
				status_due.push_back(forecast);
			end
			if (result_valid && !result_stall) begin
				results_seen++;
				if (status_due.size() == 0) begin
					flag_mismatch("transaction with nothing due, temperature",
						int'(result.temperature), 0);
				end else begin
					want = status_due.pop_front();
					if (result.bus_drive_low !== want.bus_drive_low)
						flag_mismatch("bus_drive_low", int'(result.bus_drive_low),
							int'(want.bus_drive_low));
					if (result.busy_res !== want.busy_res)
						flag_mismatch("busy_res", int'(result.busy_res),
							int'(want.busy_res));
					if (result.done_res !== want.done_res)
						flag_mismatch("done_res", int'(result.done_res),
							int'(want.done_res));
					if (result.temperature !== want.temperature)
						flag_mismatch("temperature", int'(result.temperature),
							int'(want.temperature));
				end
			end
			outstanding = status_due.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the one-wire temperature read sequencer with microsecond ticks:
// full measurement sequences whose sampled bus level spells chosen raw
// readings, stray starts and line noise, under many register settings with
// random sender gaps and receiver stalls. Checking is done by owtrs_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import owtrs_pkg::*;

	localparam int LIMIT = 5_000_000;
	localparam int RANDOM_TICKS = 1200;

	typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY} flow_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_RESET_LOW;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  tick_valid = 1'b0;
	logic                  tick_stall;
	tick_t                 tick = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;

	int    mismatches;
	int    awaited;
	int    cycles = 0;
	int    burst_left = 0;
	int    ticks_sent = 0;
	int    stall_left = 0;
	flow_t stall_mode = FLOW_FREE;
	cfg_t  live;

	one_wire_temperature_read_sequencer dut (.*);

	owtrs_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tick_valid   (tick_valid),
		.tick_stall   (tick_stall),
		.tick         (tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.errors       (mismatches),
		.outstanding  (awaited)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = flow_t'($urandom_range(0, 2));
			stall_left = $urandom_range(10, 300);
		end
		stall_left--;
		case (stall_mode)
			FLOW_FREE:  result_stall <= 1'b0;
			FLOW_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
			default:    result_stall <= 1'($urandom_range(0, 1));
		endcase
	end

	task automatic send_tick(input logic start, input logic level);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				tick_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		tick_valid <= 1'b1;
		tick <= '{start_req: start, bus_level: level};
		@(posedge clk);
		while (tick_stall) @(posedge clk);
		@(negedge clk);
		burst_left--;
		ticks_sent++;
	endtask

	task automatic drain_results();
		tick_valid <= 1'b0;
		burst_left = 0;
		while (awaited != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
	endtask

	task automatic load_regs(input cfg_t c);
		put_reg(CFG_RESET_LOW, 20'(c.reset_low_us));
		put_reg(CFG_PRESENCE_WAIT, 20'(c.presence_wait_us));
		put_reg(CFG_CONVERT_WAIT, c.convert_wait_us);
		put_reg(CFG_SLOT_START, 20'(c.slot_start_us));
		put_reg(CFG_WRITE_HOLD, 20'(c.write_hold_us));
		put_reg(CFG_RECOVERY, 20'(c.recovery_us));
		put_reg(CFG_READ_SAMPLE, 20'(c.read_sample_us));
		put_reg(CFG_READ_TAIL, 20'(c.read_tail_us));
		cfg_write <= 1'b0;
		live = c;
	endtask

	// ticks from the start tick to the first read slot
	function automatic int reads_begin(input cfg_t c);
		return 2 * (int'(c.reset_low_us) + int'(c.presence_wait_us))
			+ 32 * (int'(c.slot_start_us) + int'(c.write_hold_us) + int'(c.recovery_us))
			+ int'(c.convert_wait_us);
	endfunction

	function automatic int read_slot(input cfg_t c);
		return int'(c.slot_start_us) + int'(c.read_sample_us) + 1 + int'(c.read_tail_us);
	endfunction

	// sensor answers with raw on the sample ticks, random elsewhere
	task automatic run_measurement(input logic [15:0] raw);
		int   first;
		int   rs;
		int   total;
		int   off;
		int   i;
		logic level;
		first = reads_begin(live);
		rs = read_slot(live);
		total = first + READ_BITS * rs;
		for (i = 0; i < total; i++) begin
			level = 1'($urandom_range(0, 1));
			if (i >= first) begin
				off = i - first;
				if (off % rs == int'(live.slot_start_us) + int'(live.read_sample_us))
					level = raw[off / rs];
			end
			send_tick((i == 0) ? 1'b1 : ($urandom_range(0, 7) == 0), level);
		end
	endtask

	// random ticks, then enough quiet ticks for any started sequence to end
	task automatic line_noise();
		int n;
		int i;
		n = $urandom_range(5, 60);
		for (i = 0; i < n; i++)
			send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
		n = reads_begin(live) + READ_BITS * read_slot(live);
		for (i = 0; i < n; i++)
			send_tick(1'b0, 1'($urandom_range(0, 1)));
	endtask

	function automatic logic [15:0] pick_raw();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0:       v = 16'h8000;
			1:       v = 16'h7FFF;
			2:       v = 16'hFFFF;
			3:       v = 16'h0000;
			4:       v = 16'hFFF1;
			5:       v = 16'h0001;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic cfg_t pick_timing();
		cfg_t c;
		c.reset_low_us = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(480, 520))
			: 16'($urandom_range(0, 6));
		c.presence_wait_us = 16'($urandom_range(0, 4));
		c.convert_wait_us = ($urandom_range(0, 15) == 0) ? 20'($urandom_range(100, 300))
			: 20'($urandom_range(0, 8));
		c.slot_start_us = ($urandom_range(0, 7) == 0) ? 4'd15 : 4'($urandom_range(0, 3));
		c.write_hold_us = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(50, 70))
			: 8'($urandom_range(0, 3));
		c.recovery_us = 8'($urandom_range(0, 3));
		c.read_sample_us = ($urandom_range(0, 7) == 0) ? 4'd15 : 4'($urandom_range(0, 3));
		c.read_tail_us = 8'($urandom_range(0, 3));
		return c;
	endfunction

	initial begin
		cfg_t c;
		int   k;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// quiet ticks at reset settings
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		drain_results();

		// every segment zero: only the sample ticks remain
		c = '0;
		load_regs(c);
		run_measurement(16'h8000);
		send_tick(1'b0, 1'b1);
		drain_results();

		while (ticks_sent < RANDOM_TICKS) begin
			load_regs(pick_timing());
			repeat ($urandom_range(1, 3)) begin
				for (k = $urandom_range(0, 3); k > 0; k--)
					send_tick(1'b0, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 5) == 0) line_noise();
				else run_measurement(pick_raw());
			end
			drain_results();
		end

		c = pick_timing();
		c.convert_wait_us = 20'hFFFFF;
		load_regs(c);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		drain_results();

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/owtrs_pkg.sv
rtl/one_wire_temperature_read_sequencer.sv
verif/owtrs_checker.sv
verif/tb_top.sv
